>>> hw/rtl/scr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types and codes of the surface correlation router.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam logic [1:0] CMD_ATTACH     = 2'd0;
  localparam logic [1:0] CMD_DETACH     = 2'd1;
  localparam logic [1:0] CMD_DETACH_ALL = 2'd2;
  localparam logic [1:0] CMD_ROUTE      = 2'd3;

  localparam logic [3:0] ST_ATTACHED     = 4'd0;
  localparam logic [3:0] ST_INVALID      = 4'd1;
  localparam logic [3:0] ST_DUP_SURFACE  = 4'd2;
  localparam logic [3:0] ST_FULL         = 4'd3;
  localparam logic [3:0] ST_DUP_CORR     = 4'd4;
  localparam logic [3:0] ST_DETACHED     = 4'd5;
  localparam logic [3:0] ST_REFUSED      = 4'd6;
  localparam logic [3:0] ST_CLEARED      = 4'd7;
  localparam logic [3:0] ST_DELIVERED    = 4'd8;
  localparam logic [3:0] ST_STALE        = 4'd9;
  localparam logic [3:0] ST_NO_DEST      = 4'd10;
  localparam logic [3:0] ST_UNK_SURFACE  = 4'd11;
  localparam logic [3:0] ST_UNK_CORR     = 4'd12;
  localparam logic [3:0] ST_CONFLICT     = 4'd13;

  // slot entry: surface id, key generation, endpoint
  localparam int SLOT_W = 136;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] surface_id;
    logic [63:0] surface_generation;
    logic        has_surface;
    logic [63:0] message_generation;
    logic [63:0] correlation;
    logic        correlation_present;
    logic        last_in_group;
    logic [7:0]  endpoint_id;
  } scr_in_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] dest_endpoint;
    logic [3:0] dest_slot;
    logic [4:0] occupied_count;
  } scr_out_t;

endpackage

>>> hw/rtl/scr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/surface_correlation_router_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surface_correlation_router_core
// Routing table of surface keys and correlation ids, walked in memory.
// ----------------------------------------------------------------------------
// channel  ports                          handshake
// in       start, busy, in_word           taken when start & !busy
// out      out_valid, out_word            one-cycle strobe, no stall
// cfg      cfg_valid, cfg_ready, cfg_data taken when valid & ready
//
// Non-final attach items and detach all finish in IDLE without raising busy.
// Detach and route by surface walk the slot memory, one slot a cycle.
// Correlation lookups walk the correlation memory, one entry a cycle; an
// attach then writes one entry a cycle. The result strobe rises as busy
// drops. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module surface_correlation_router_core
  import scr_pkg::*;
#(
  parameter int MAX_SURFACES     = 16,
  parameter int MAX_CORRELATIONS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  scr_in_t     in_word,
  output logic        out_valid,
  output scr_out_t    out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  localparam int S   = MAX_SURFACES;
  localparam int C   = MAX_CORRELATIONS;
  localparam int SW  = (S > 1) ? $clog2(S) : 1;
  localparam int KW  = (C > 1) ? $clog2(C) : 1;
  localparam int KCW = $clog2(C + 1);
  localparam int SCW = $clog2(S + 1);
  localparam int EW  = (S * C > 1) ? $clog2(S * C) : 1;

  localparam logic [2:0] IDLE   = 3'd0;
  localparam logic [2:0] SWALK  = 3'd1;
  localparam logic [2:0] CWALK  = 3'd2;
  localparam logic [2:0] EPRD   = 3'd3;
  localparam logic [2:0] EPWAIT = 3'd4;
  localparam logic [2:0] WR     = 3'd5;

  logic [2:0]     state_r, state_nxt;
  scr_in_t        req_r, req_nxt;
  logic [63:0]    gen_r, gen_nxt;
  logic [63:0]    pend_r [C];
  logic [63:0]    pend_nxt [C];
  logic [KCW-1:0] pcnt_r, pcnt_nxt;
  logic           perr_r, perr_nxt;
  logic [S-1:0]   valid_r, valid_nxt;
  logic [KCW-1:0] cnt_r [S];
  logic [KCW-1:0] cnt_nxt [S];
  logic [SW-1:0]  sa_r, sa_nxt;
  logic [EW-1:0]  ca_r, ca_nxt;
  logic [SW-1:0]  cs_r, cs_nxt;
  logic [KW-1:0]  ck_r, ck_nxt;
  logic           iss_r, iss_nxt;
  logic           rv_r, rv_nxt;
  logic           rlast_r, rlast_nxt;
  logic [SW-1:0]  rs_r, rs_nxt;
  logic [KW-1:0]  rk_r, rk_nxt;
  logic           found_r, found_nxt;
  logic [SW-1:0]  bys_r, bys_nxt;
  logic [7:0]     sep_r, sep_nxt;
  logic           cfound_r, cfound_nxt;
  logic [SW-1:0]  byc_r, byc_nxt;
  logic [C-1:0]   intab_r, intab_nxt;
  logic [SW-1:0]  free_r, free_nxt;
  logic [KW-1:0]  wk_r, wk_nxt;
  logic           ov_r, ov_nxt;
  scr_out_t       out_r, out_nxt;

  logic              slot_we;
  logic [SW-1:0]     slot_raddr;
  logic [SLOT_W-1:0] slot_wdata, slot_rdata;
  logic              corr_we;
  logic [EW-1:0]     corr_waddr;
  logic [63:0]       corr_wdata, corr_rdata;

  scr_ram #(.WIDTH(SLOT_W), .DEPTH(S)) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (free_r),
    .wr_data (slot_wdata),
    .rd_addr (slot_raddr),
    .rd_data (slot_rdata)
  );

  scr_ram #(.WIDTH(64), .DEPTH(S * C)) u_corr_ram (
    .clk     (clk),
    .wr_en   (corr_we),
    .wr_addr (corr_waddr),
    .wr_data (corr_wdata),
    .rd_addr (ca_r),
    .rd_data (corr_rdata)
  );

  assign busy      = (state_r != IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_word  = out_r;

  assign slot_raddr = (state_r == EPRD) ? byc_r : sa_r;
  assign slot_wdata = {req_r.surface_id, req_r.surface_generation, req_r.endpoint_id};
  assign slot_we    = (state_r == WR);
  assign corr_we    = (state_r == WR) && (KCW'(wk_r) < pcnt_r);
  assign corr_waddr = EW'(32'(free_r) * C + 32'(wk_r));
  assign corr_wdata = pend_r[wk_r];

  logic          smatch, shit, ent_ok, chit;
  logic          found_e, cfound_e;
  logic [SW-1:0] bys_e, byc_e;
  logic [7:0]    sep_e;
  logic [C-1:0]  intab_e;
  logic [3:0]    att_st;
  logic          any_free;
  logic [SW-1:0] free_idx;
  logic [SCW-1:0] occ;

  always_comb begin
    logic done;
    logic bad;
    smatch = (slot_rdata[135:72] == req_r.surface_id) &&
             (slot_rdata[71:8] == req_r.surface_generation);
    shit    = rv_r && (state_r == SWALK) && valid_r[rs_r] && smatch && !found_r;
    found_e = found_r | shit;
    bys_e   = shit ? rs_r : bys_r;
    sep_e   = shit ? slot_rdata[7:0] : sep_r;
    ent_ok  = rv_r && (state_r == CWALK) && valid_r[rs_r] &&
              (8'(rk_r) < 8'(cnt_r[rs_r]));
    chit     = ent_ok && (corr_rdata == req_r.correlation) && !cfound_r;
    cfound_e = cfound_r | chit;
    byc_e    = chit ? rs_r : byc_r;
    for (int i = 0; i < C; i++) begin
      intab_e[i] = intab_r[i] | (ent_ok && (corr_rdata == pend_r[i]));
    end
    att_st = ST_ATTACHED;
    done   = 1'b0;
    for (int i = 0; i < C; i++) begin
      bad = (pend_r[i] == 64'd0);
      for (int j = 0; j < i; j++) begin
        bad = bad | (pend_r[j] == pend_r[i]);
      end
      if (!done && (KCW'(i) < pcnt_r)) begin
        if (bad) begin
          att_st = ST_INVALID;
          done   = 1'b1;
        end else if (intab_e[i]) begin
          att_st = ST_DUP_CORR;
          done   = 1'b1;
        end
      end
    end
    any_free = 1'b0;
    free_idx = '0;
    for (int s = S - 1; s >= 0; s--) begin
      if (!valid_r[s]) begin
        any_free = 1'b1;
        free_idx = SW'(s);
      end
    end
  end

  always_comb begin
    logic       emit;
    logic [3:0] est;
    logic [7:0] eep;
    logic [SW-1:0] eslot;
    logic       go_s, go_c;
    state_nxt  = state_r;
    req_nxt    = req_r;
    gen_nxt    = gen_r;
    pend_nxt   = pend_r;
    pcnt_nxt   = pcnt_r;
    perr_nxt   = perr_r;
    valid_nxt  = valid_r;
    cnt_nxt    = cnt_r;
    sa_nxt     = sa_r;
    ca_nxt     = ca_r;
    cs_nxt     = cs_r;
    ck_nxt     = ck_r;
    iss_nxt    = iss_r;
    rv_nxt     = 1'b0;
    rlast_nxt  = 1'b0;
    rs_nxt     = rs_r;
    rk_nxt     = rk_r;
    found_nxt  = found_e;
    bys_nxt    = bys_e;
    sep_nxt    = sep_e;
    cfound_nxt = cfound_e;
    byc_nxt    = byc_e;
    intab_nxt  = intab_e;
    free_nxt   = free_r;
    wk_nxt     = wk_r;
    emit  = 1'b0;
    est   = ST_ATTACHED;
    eep   = 8'd0;
    eslot = '0;
    go_s  = 1'b0;
    go_c  = 1'b0;

    if (cfg_valid && (cfg_data != 64'd0)) begin
      gen_nxt = cfg_data;
    end

    unique case (state_r)
      IDLE: begin
        if (start) begin
          req_nxt = in_word;
          unique case (in_word.command)
            CMD_ATTACH: begin
              if (in_word.correlation_present) begin
                if (pcnt_r < KCW'(C)) begin
                  pend_nxt[pcnt_r[KW-1:0]] = in_word.correlation;
                  pcnt_nxt = pcnt_r + KCW'(1);
                end else begin
                  perr_nxt = 1'b1;
                end
              end
              if (in_word.last_in_group) begin
                if (in_word.surface_id == 64'd0 || in_word.surface_generation != gen_r ||
                    perr_nxt) begin
                  emit = 1'b1;
                  est  = ST_INVALID;
                end else begin
                  go_s = 1'b1;
                end
              end
            end
            CMD_DETACH: begin
              if (in_word.surface_id == 64'd0 || in_word.surface_generation != gen_r) begin
                emit = 1'b1;
                est  = ST_REFUSED;
              end else begin
                go_s = 1'b1;
              end
            end
            CMD_DETACH_ALL: begin
              valid_nxt = '0;
              emit = 1'b1;
              est  = ST_CLEARED;
            end
            CMD_ROUTE: begin
              if (in_word.message_generation != gen_r) begin
                emit = 1'b1;
                est  = ST_STALE;
              end else if (in_word.has_surface && (in_word.surface_id == 64'd0 ||
                           in_word.surface_generation != gen_r)) begin
                emit = 1'b1;
                est  = ST_STALE;
              end else if (!in_word.has_surface && in_word.correlation == 64'd0) begin
                emit = 1'b1;
                est  = ST_NO_DEST;
              end else if (in_word.has_surface) begin
                go_s = 1'b1;
              end else begin
                go_c = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      SWALK: begin
        if (iss_r) begin
          rv_nxt    = 1'b1;
          rs_nxt    = sa_r;
          rlast_nxt = (sa_r == SW'(S - 1));
          iss_nxt   = (sa_r != SW'(S - 1));
          sa_nxt    = sa_r + SW'(1);
        end
        if (rv_r && rlast_r) begin
          unique case (req_r.command)
            CMD_ATTACH: begin
              if (found_e) begin
                emit = 1'b1;
                est  = ST_DUP_SURFACE;
              end else if (!any_free) begin
                emit = 1'b1;
                est  = ST_FULL;
              end else begin
                free_nxt = free_idx;
                if (pcnt_r == '0) begin
                  state_nxt = WR;
                  wk_nxt    = '0;
                end else begin
                  go_c = 1'b1;
                end
              end
            end
            CMD_DETACH: begin
              emit = 1'b1;
              if (!found_e) begin
                est = ST_DETACHED;
              end else if (sep_e != req_r.endpoint_id) begin
                est = ST_REFUSED;
              end else begin
                est = ST_DETACHED;
                valid_nxt[bys_e] = 1'b0;
              end
            end
            default: begin
              if (!found_e) begin
                emit = 1'b1;
                est  = ST_UNK_SURFACE;
              end else if (req_r.correlation != 64'd0) begin
                go_c = 1'b1;
              end else begin
                emit  = 1'b1;
                est   = ST_DELIVERED;
                eep   = sep_e;
                eslot = bys_e;
              end
            end
          endcase
        end
      end
      CWALK: begin
        if (iss_r) begin
          rv_nxt    = 1'b1;
          rs_nxt    = cs_r;
          rk_nxt    = ck_r;
          rlast_nxt = (ca_r == EW'(S * C - 1));
          iss_nxt   = (ca_r != EW'(S * C - 1));
          ca_nxt    = ca_r + EW'(1);
          if (ck_r == KW'(C - 1)) begin
            ck_nxt = '0;
            cs_nxt = cs_r + SW'(1);
          end else begin
            ck_nxt = ck_r + KW'(1);
          end
        end
        if (rv_r && rlast_r) begin
          if (req_r.command == CMD_ATTACH) begin
            if (att_st != ST_ATTACHED) begin
              emit = 1'b1;
              est  = att_st;
            end else begin
              state_nxt = WR;
              wk_nxt    = '0;
            end
          end else if (!cfound_e) begin
            emit = 1'b1;
            est  = ST_UNK_CORR;
          end else if (req_r.has_surface && (bys_r != byc_e)) begin
            emit = 1'b1;
            est  = ST_CONFLICT;
          end else if (req_r.has_surface) begin
            emit  = 1'b1;
            est   = ST_DELIVERED;
            eep   = sep_r;
            eslot = byc_e;
          end else begin
            state_nxt = EPRD;
          end
        end
      end
      EPRD: begin
        state_nxt = EPWAIT;
      end
      EPWAIT: begin
        emit  = 1'b1;
        est   = ST_DELIVERED;
        eep   = slot_rdata[7:0];
        eslot = byc_r;
      end
      WR: begin
        if (KCW'(wk_r) + KCW'(1) >= pcnt_r) begin
          valid_nxt[free_r] = 1'b1;
          cnt_nxt[free_r]   = pcnt_r;
          emit = 1'b1;
          est  = ST_ATTACHED;
        end else begin
          wk_nxt = wk_r + KW'(1);
        end
      end
      default: state_nxt = IDLE;
    endcase

    if (go_s) begin
      state_nxt = SWALK;
      sa_nxt    = '0;
      iss_nxt   = 1'b1;
      found_nxt = 1'b0;
    end
    if (go_c) begin
      state_nxt  = CWALK;
      ca_nxt     = '0;
      cs_nxt     = '0;
      ck_nxt     = '0;
      iss_nxt    = 1'b1;
      cfound_nxt = 1'b0;
      intab_nxt  = '0;
    end

    occ = '0;
    for (int s = 0; s < S; s++) begin
      occ = occ + SCW'(valid_nxt[s]);
    end
    ov_nxt  = emit;
    out_nxt = out_r;
    if (emit) begin
      state_nxt = IDLE;
      out_nxt.status         = est;
      out_nxt.dest_endpoint  = eep;
      out_nxt.dest_slot      = 4'(eslot);
      out_nxt.occupied_count = 5'(occ);
      if (req_nxt.command == CMD_ATTACH) begin
        pcnt_nxt = '0;
        perr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      gen_r   <= 64'd1;
      pcnt_r  <= '0;
      perr_r  <= 1'b0;
      valid_r <= '0;
      iss_r   <= 1'b0;
      rv_r    <= 1'b0;
      rlast_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
      pcnt_r  <= pcnt_nxt;
      perr_r  <= perr_nxt;
      valid_r <= valid_nxt;
      iss_r   <= iss_nxt;
      rv_r    <= rv_nxt;
      rlast_r <= rlast_nxt;
      ov_r    <= ov_nxt;
    end
    req_r    <= req_nxt;
    pend_r   <= pend_nxt;
    cnt_r    <= cnt_nxt;
    sa_r     <= sa_nxt;
    ca_r     <= ca_nxt;
    cs_r     <= cs_nxt;
    ck_r     <= ck_nxt;
    rs_r     <= rs_nxt;
    rk_r     <= rk_nxt;
    found_r  <= found_nxt;
    bys_r    <= bys_nxt;
    sep_r    <= sep_nxt;
    cfound_r <= cfound_nxt;
    byc_r    <= byc_nxt;
    intab_r  <= intab_nxt;
    free_r   <= free_nxt;
    wk_r     <= wk_nxt;
    out_r    <= out_nxt;
  end

endmodule

>>> hw/rtl/scr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_checker
// Port-level checks of the router core, bound into the router core module.
// ----------------------------------------------------------------------------
module scr_checker
  import scr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input scr_out_t out_word
);

  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result word without a command");

  a_no_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_DELIVERED |->
      out_word.dest_endpoint == 8'd0 && out_word.dest_slot == 4'd0)
    else $error("destination on a non-delivered word");

  a_deliver_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_DELIVERED |-> out_word.occupied_count != 5'd0)
    else $error("delivered with empty table");

  a_clear_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_CLEARED |-> out_word.occupied_count == 5'd0)
    else $error("table not empty after clear");

  a_reset_quiet: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result word right after reset");

endmodule

bind surface_correlation_router_core scr_checker u_scr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for surface_correlation_router_core. A queue of command
// words feeds a clocked driver with random gaps; each accepted word runs
// through a local routing-table predictor, and a clocked monitor compares
// every result strobe field by field against the oldest predicted result.
// Phases run under several launch generations written through cfg.
// ----------------------------------------------------------------------------
module tb_top;
  import scr_pkg::*;

  localparam int NSURF = 16;
  localparam int NCORR = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  scr_in_t     in_word = '0;
  logic        out_valid;
  scr_out_t    out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;

  surface_correlation_router_core #(
    .MAX_SURFACES(NSURF),
    .MAX_CORRELATIONS(NCORR)
  ) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // routing table mirror
  logic [63:0] tbl_gen;
  bit          tbl_valid [NSURF];
  logic [63:0] tbl_sid   [NSURF];
  logic [63:0] tbl_kgen  [NSURF];
  logic [7:0]  tbl_ep    [NSURF];
  logic [63:0] tbl_corr  [NSURF*NCORR];
  bit          tbl_cval  [NSURF*NCORR];
  logic [63:0] grp_corr  [NCORR];
  int          grp_cnt;
  bit          grp_err;

  scr_in_t  word_q[$];
  scr_out_t result_q[$];
  int       gap_cnt = 0;
  bit       gap_off = 0;
  int       errors = 0;
  logic [63:0] cur_gen = 64'd1;

  function automatic void queue_word(scr_in_t w);
    word_q = {word_q, w};
  endfunction

  function automatic void queue_result(scr_out_t r);
    result_q = {result_q, r};
  endfunction

  function automatic int find_surface(logic [63:0] id, logic [63:0] g);
    for (int s = 0; s < NSURF; s++)
      if (tbl_valid[s] && tbl_sid[s] == id && tbl_kgen[s] == g) return s;
    return -1;
  endfunction

  function automatic int find_corr(logic [63:0] c);
    for (int s = 0; s < NSURF; s++)
      if (tbl_valid[s])
        for (int k = 0; k < NCORR; k++)
          if (tbl_cval[s*NCORR+k] && tbl_corr[s*NCORR+k] == c) return s;
    return -1;
  endfunction

  function automatic logic [3:0] close_group(scr_in_t w);
    int fs;
    fs = -1;
    if (w.surface_id == 0 || w.surface_generation != tbl_gen || grp_err) return ST_INVALID;
    if (find_surface(w.surface_id, w.surface_generation) >= 0) return ST_DUP_SURFACE;
    for (int s = NSURF - 1; s >= 0; s--) if (!tbl_valid[s]) fs = s;
    if (fs < 0) return ST_FULL;
    for (int i = 0; i < grp_cnt; i++) begin
      if (grp_corr[i] == 0) return ST_INVALID;
      for (int j = 0; j < i; j++) if (grp_corr[j] == grp_corr[i]) return ST_INVALID;
      if (find_corr(grp_corr[i]) >= 0) return ST_DUP_CORR;
    end
    tbl_valid[fs] = 1;
    tbl_sid[fs] = w.surface_id;
    tbl_kgen[fs] = w.surface_generation;
    tbl_ep[fs] = w.endpoint_id;
    for (int k = 0; k < NCORR; k++) begin
      tbl_cval[fs*NCORR+k] = k < grp_cnt;
      tbl_corr[fs*NCORR+k] = k < grp_cnt ? grp_corr[k] : 64'd0;
    end
    return ST_ATTACHED;
  endfunction

  function automatic bit predict_word(scr_in_t w, output scr_out_t r);
    int bs, bc, n;
    r = '0;
    bs = -1;
    bc = -1;
    n = 0;
    case (w.command)
      CMD_ATTACH: begin
        if (w.correlation_present) begin
          if (grp_cnt < NCORR) begin
            grp_corr[grp_cnt] = w.correlation;
            grp_cnt++;
          end else grp_err = 1;
        end
        if (!w.last_in_group) return 0;
        r.status = close_group(w);
        grp_cnt = 0;
        grp_err = 0;
      end
      CMD_DETACH: begin
        if (w.surface_id == 0 || w.surface_generation != tbl_gen) r.status = ST_REFUSED;
        else begin
          bs = find_surface(w.surface_id, w.surface_generation);
          if (bs < 0) r.status = ST_DETACHED;
          else if (tbl_ep[bs] != w.endpoint_id) r.status = ST_REFUSED;
          else begin
            tbl_valid[bs] = 0;
            for (int k = 0; k < NCORR; k++) tbl_cval[bs*NCORR+k] = 0;
            r.status = ST_DETACHED;
          end
        end
      end
      CMD_DETACH_ALL: begin
        for (int s = 0; s < NSURF; s++) tbl_valid[s] = 0;
        for (int e = 0; e < NSURF*NCORR; e++) tbl_cval[e] = 0;
        r.status = ST_CLEARED;
      end
      default: begin
        if (w.message_generation != tbl_gen) r.status = ST_STALE;
        else if (w.has_surface && (w.surface_id == 0 || w.surface_generation != tbl_gen))
          r.status = ST_STALE;
        else if (!w.has_surface && w.correlation == 0) r.status = ST_NO_DEST;
        else begin
          if (w.has_surface) bs = find_surface(w.surface_id, w.surface_generation);
          if (w.correlation != 0) bc = find_corr(w.correlation);
          if (w.has_surface && bs < 0) r.status = ST_UNK_SURFACE;
          else if (w.correlation != 0 && bc < 0) r.status = ST_UNK_CORR;
          else if (bs >= 0 && bc >= 0 && bs != bc) r.status = ST_CONFLICT;
          else begin
            if (bs < 0) bs = bc;
            r.status = ST_DELIVERED;
            r.dest_endpoint = tbl_ep[bs];
            r.dest_slot = bs[3:0];
          end
        end
      end
    endcase
    for (int s = 0; s < NSURF; s++) if (tbl_valid[s]) n++;
    r.occupied_count = n[4:0];
    return 1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_off || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin : driver
    bit took;
    scr_out_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        if (predict_word(in_word, r)) queue_result(r);
        void'(word_q.pop_front());
      end
      if (!start || took) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          start <= 1'b0;
        end else if (word_q.size() > 0 && !cfg_valid) begin
          start <= 1'b1;
          in_word <= word_q[0];
          gap_cnt <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    scr_out_t e;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) report("unexpected word", 64'(out_word), 64'd0);
      else begin
        e = result_q.pop_front();
        if (out_word.status != e.status)
          report("status", 64'(out_word.status), 64'(e.status));
        if (out_word.dest_endpoint != e.dest_endpoint)
          report("dest_endpoint", 64'(out_word.dest_endpoint), 64'(e.dest_endpoint));
        if (out_word.dest_slot != e.dest_slot)
          report("dest_slot", 64'(out_word.dest_slot), 64'(e.dest_slot));
        if (out_word.occupied_count != e.occupied_count)
          report("occupied_count", 64'(out_word.occupied_count), 64'(e.occupied_count));
      end
    end
  end

  function automatic logic [63:0] pick_sid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 64'd0;
    if (r < 10) return {$urandom, $urandom};
    if (r < 13) return '1;
    return 64'd0 + $urandom_range(1, 20);
  endfunction

  function automatic logic [63:0] pick_corr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 64'd0;
    if (r < 10) return {$urandom, $urandom};
    if (r < 13) return '1;
    return 64'h100 + $urandom_range(1, 40);
  endfunction

  function automatic logic [63:0] pick_gen();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return cur_gen;
    if (r < 90) return 64'd0;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] pick_ep();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(0, 4));
    if (r < 8) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic scr_in_t mk(logic [1:0] cmd, logic [63:0] sid, logic [63:0] sg,
                                 bit hs, logic [63:0] mg, logic [63:0] c, bit p, bit l,
                                 logic [7:0] ep);
    scr_in_t w;
    w.command = cmd;
    w.surface_id = sid;
    w.surface_generation = sg;
    w.has_surface = hs;
    w.message_generation = mg;
    w.correlation = c;
    w.correlation_present = p;
    w.last_in_group = l;
    w.endpoint_id = ep;
    return w;
  endfunction

  function automatic scr_in_t junk(logic [1:0] cmd);
    scr_in_t w;
    logic [287:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
    w = raw[$bits(scr_in_t)-1:0];
    w.command = cmd;
    return w;
  endfunction

  // attach group: n non-final items, most carrying a correlation, then a closing item carrying the key
  task automatic push_group(int n, logic [63:0] sid, logic [63:0] sg, logic [7:0] ep);
    scr_in_t w;
    for (int i = 0; i < n; i++) begin
      w = junk(CMD_ATTACH);
      w.correlation = pick_corr();
      w.correlation_present = $urandom_range(0, 9) != 0;
      w.last_in_group = 0;
      queue_word(w);
      if ($urandom_range(0, 19) == 0) begin
        w = junk(CMD_ROUTE);
        w.message_generation = cur_gen;
        queue_word(w);
      end
    end
    w = junk(CMD_ATTACH);
    w.surface_id = sid;
    w.surface_generation = sg;
    w.endpoint_id = ep;
    w.correlation = pick_corr();
    w.correlation_present = $urandom_range(0, 2) == 0;
    w.last_in_group = 1;
    queue_word(w);
  endtask

  task automatic push_random(int count);
    scr_in_t w;
    int k, n;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 42) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 3);
        push_group(n, pick_sid(), pick_gen(), pick_ep());
      end else if (k < 80) begin
        w = junk(CMD_ROUTE);
        w.has_surface = 1'($urandom_range(0, 1));
        w.surface_id = pick_sid();
        w.surface_generation = pick_gen();
        w.message_generation = pick_gen();
        w.correlation = ($urandom_range(0, 2) == 0) ? 64'd0 : pick_corr();
        queue_word(w);
      end else if (k < 93) begin
        w = junk(CMD_DETACH);
        w.surface_id = pick_sid();
        w.surface_generation = pick_gen();
        w.endpoint_id = pick_ep();
        queue_word(w);
      end else if (k < 96) begin
        queue_word(junk(CMD_DETACH_ALL));
      end else begin
        w = junk(2'($urandom_range(0, 3)));
        queue_word(w);
      end
    end
  endtask

  task automatic wait_idle();
    while (word_q.size() > 0 || start || busy || result_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_gen(logic [63:0] g);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (g != 0) tbl_gen = g;
    if (g != 0) cur_gen = g;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    tbl_gen = 64'd1;
    grp_cnt = 0;
    grp_err = 0;
    for (int s = 0; s < NSURF; s++) begin
      tbl_valid[s] = 0;
      tbl_sid[s] = 0;
      tbl_kgen[s] = 0;
      tbl_ep[s] = 0;
    end
    for (int e = 0; e < NSURF*NCORR; e++) begin
      tbl_cval[e] = 0;
      tbl_corr[e] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    queue_word(mk(CMD_ATTACH, 64'd5, 64'd1, 0, 0, 0, 0, 1, 8'd1));
    queue_word(mk(CMD_ATTACH, 0, 0, 0, 0, 64'd11, 1, 0, 0));
    queue_word(mk(CMD_ROUTE, 64'd5, 64'd1, 1, 64'd1, 0, 0, 0, 0));
    queue_word(mk(CMD_ATTACH, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_word(mk(CMD_ATTACH, '1, 64'd1, 0, 0, '1, 1, 1, 8'hFF));
    queue_word(mk(CMD_ATTACH, 64'd5, 64'd1, 0, 0, 64'd12, 1, 1, 8'd2));
    queue_word(mk(CMD_ATTACH, 0, 64'd1, 0, 0, 64'd13, 1, 1, 8'd2));
    queue_word(mk(CMD_ATTACH, 64'd6, 64'd1, 0, 0, 0, 1, 1, 8'd2));
    queue_word(mk(CMD_ATTACH, 64'd6, 64'd1, 0, 0, 64'd14, 1, 0, 8'd2));
    queue_word(mk(CMD_ATTACH, 64'd6, 64'd1, 0, 0, 64'd14, 1, 1, 8'd2));
    queue_word(mk(CMD_ATTACH, 64'd6, 64'd1, 0, 0, '1, 1, 1, 8'd2));
    for (int i = 0; i < 9; i++)
      queue_word(mk(CMD_ATTACH, 64'd7, 64'd1, 0, 0, 64'd20 + i, 1, i == 8, 8'd3));
    queue_word(mk(CMD_ROUTE, '1, 64'd1, 1, 64'd1, 64'd11, 0, 0, 0));
    queue_word(mk(CMD_ROUTE, 64'd5, 64'd1, 1, 64'd1, '1, 0, 0, 0));
    queue_word(mk(CMD_ROUTE, 0, 0, 0, 64'd2, 64'd11, 0, 0, 0));
    queue_word(mk(CMD_ROUTE, 0, 64'd1, 1, 64'd1, 0, 0, 0, 0));
    queue_word(mk(CMD_ROUTE, 0, 0, 0, 64'd1, 0, 0, 0, 0));
    queue_word(mk(CMD_ROUTE, 64'd9, 64'd1, 1, 64'd1, 0, 0, 0, 0));
    queue_word(mk(CMD_ROUTE, 0, 0, 0, 64'd1, 64'd99, 0, 0, 0));
    queue_word(mk(CMD_DETACH, 64'd5, 64'd1, 0, 0, 0, 0, 0, 8'd9));
    queue_word(mk(CMD_DETACH, 64'd9, 64'd1, 0, 0, 0, 0, 0, 8'd9));
    queue_word(mk(CMD_DETACH, 0, 64'd1, 0, 0, 0, 0, 0, 8'd1));
    queue_word(mk(CMD_DETACH, 64'd5, 64'd1, 0, 0, 0, 0, 0, 8'd1));
    queue_word(mk(CMD_DETACH_ALL, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    push_random(94);
    wait_idle();
    write_gen('1);
    gap_off = 1;
    push_random(70);
    wait_idle();
    gap_off = 0;
    write_gen(64'd0);
    push_random(70);
    wait_idle();
    write_gen({$urandom, $urandom} | 64'd1);
    push_random(70);
    wait_idle();
    write_gen(64'd1);
    push_random(70);
    wait_idle();

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
